/* rtl/hlrc_pkg.sv */
`default_nettype none

package hlrc_pkg;

  localparam int NODES     = 64;
  localparam int NODE_W    = $clog2(NODES);
  localparam int FIELD_W   = 6;
  localparam int HOP_W     = 8;
  localparam int CNT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int CNT_STEPS = (NODES + 7) / 8;
  localparam int STEP_W    = (CNT_STEPS > 1) ? $clog2(CNT_STEPS) : 1;

  localparam logic [FIELD_W:0] NODES_LIM = (FIELD_W + 1)'(NODES);

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef logic [NODES-1:0] row_t;

  typedef struct packed {
    logic cap;
    logic clear;
    logic rd_a;
    logic rd_b;
    logic wr_a;
    logic wr_b;
    logic q_init;
    logic scan_start;
    logic scan_step;
    logic hop_end;
    logic cnt_start;
    logic cnt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic walk_done;
    logic scan_done;
    logic cnt_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/hlrc_if.sv */
`default_nettype none

interface hlrc_req_if;
  logic                          valid;
  logic                          ready;
  logic [hlrc_pkg::MODE_W-1:0]   mode;
  logic [hlrc_pkg::FIELD_W-1:0]  node_a;
  logic [hlrc_pkg::FIELD_W-1:0]  node_b;
  logic [hlrc_pkg::HOP_W-1:0]    hop_limit;

  modport source (output valid, mode, node_a, node_b, hop_limit, input ready);
  modport sink (input valid, mode, node_a, node_b, hop_limit, output ready);
endinterface

interface hlrc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hlrc_pkg::CNT_W-1:0]    unreachable_count;
  logic [hlrc_pkg::FIELD_W-1:0]  source_echo;
  logic [hlrc_pkg::HOP_W-1:0]    hop_echo;

  modport source (output valid, unreachable_count, source_echo, hop_echo, input ready);
  modport sink (input valid, unreachable_count, source_echo, hop_echo, output ready);
endinterface

`default_nettype wire

/* rtl/hop_limited_reachability_count.sv */
// Hop-limited breadth-first reachability over a 64-node undirected network.
// Request channel (req_i): mode, node_a, node_b, hop_limit. Mode 0 adds an
// edge, mode 2 clears the network, mode 1 queries; mode 3 is dropped.
// Response channel (rsp_o): one response per query with the count of named
// nodes not reached within hop_limit hops, plus the echoed source and limit.
// An edge add reads and writes the row of node_a, then that of node_b; a
// clear empties the row valid bits and the named-node set. A query walks
// the hop levels, reading one adjacency row from the row memory per
// frontier node at each level, then counts unreached nodes byte-wise over
// the eight bytes of the set and loads the output register.
// One request is worked at a time; ready is high only when idle.
// A finished response waits in an output register, so new requests are
// taken while the receiver stalls; a second query holds in its last state
// until the pending response is taken.
// Reset (rst_ni low, asynchronous) empties the network and drops any
// pending response; row valid bits make the memory read as zero at once.
`default_nettype none

module hop_limited_reachability_count (
  input  wire        clk_i,
  input  wire        rst_ni,
  hlrc_req_if.sink   req_i,
  hlrc_rsp_if.source rsp_o
);

  hlrc_pkg::cmd_t    cmd;
  hlrc_pkg::status_t status;

  hlrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .mode_i     (req_i.mode),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hlrc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .node_a_i            (req_i.node_a),
    .node_b_i            (req_i.node_b),
    .hop_limit_i         (req_i.hop_limit),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .unreachable_count_o (rsp_o.unreachable_count),
    .source_echo_o       (rsp_o.source_echo),
    .hop_echo_o          (rsp_o.hop_echo)
  );

endmodule

`default_nettype wire

/* rtl/hlrc_datapath.sv */
`default_nettype none

module hlrc_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire hlrc_pkg::cmd_t           cmd_i,
  output hlrc_pkg::status_t             status_o,
  input  wire [hlrc_pkg::FIELD_W-1:0]   node_a_i,
  input  wire [hlrc_pkg::FIELD_W-1:0]   node_b_i,
  input  wire [hlrc_pkg::HOP_W-1:0]     hop_limit_i,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic [hlrc_pkg::CNT_W-1:0]    unreachable_count_o,
  output logic [hlrc_pkg::FIELD_W-1:0]  source_echo_o,
  output logic [hlrc_pkg::HOP_W-1:0]    hop_echo_o
);

  localparam int SH_W = hlrc_pkg::CNT_STEPS * 8;

  hlrc_pkg::row_t mem [hlrc_pkg::NODES];

  logic [hlrc_pkg::FIELD_W-1:0] a_q, b_q;
  logic [hlrc_pkg::HOP_W-1:0]   hop_q, hops_left_q;
  logic [hlrc_pkg::NODES-1:0]   row_vld_q;
  hlrc_pkg::row_t               rd_data_q;
  logic                         rd_vld_q;
  logic                         rd_pend_q;
  hlrc_pkg::row_t               present_q, reached_q, frontier_q, pend_q, acc_q;
  logic [SH_W-1:0]              sh_q;
  logic [hlrc_pkg::CNT_W-1:0]   cnt_q;
  logic [hlrc_pkg::STEP_W-1:0]  step_q;
  logic                         out_vld_q;
  logic [hlrc_pkg::CNT_W-1:0]   out_cnt_q;
  logic [hlrc_pkg::FIELD_W-1:0] out_src_q;
  logic [hlrc_pkg::HOP_W-1:0]   out_hop_q;

  logic [hlrc_pkg::NODE_W-1:0]  ffs_idx;
  logic [hlrc_pkg::NODE_W-1:0]  rd_addr;
  logic [hlrc_pkg::NODE_W-1:0]  wr_addr;
  logic                         wr_en;
  hlrc_pkg::row_t               row_eff;
  hlrc_pkg::row_t               wr_data;
  hlrc_pkg::row_t               next_set;
  hlrc_pkg::row_t               src_bit;
  logic                         src_ok;

  always_comb begin
    ffs_idx = '0;
    for (int i = hlrc_pkg::NODES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        ffs_idx = hlrc_pkg::NODE_W'(i);
      end
    end
  end

  assign row_eff  = rd_vld_q ? rd_data_q : '0;
  assign next_set = acc_q & ~reached_q;
  assign src_ok   = {1'b0, node_a_i} < hlrc_pkg::NODES_LIM;
  assign src_bit  = src_ok ? (hlrc_pkg::row_t'(1) << node_a_i[hlrc_pkg::NODE_W-1:0]) : '0;

  always_comb begin
    rd_addr = ffs_idx;
    if (cmd_i.rd_a) begin
      rd_addr = a_q[hlrc_pkg::NODE_W-1:0];
    end else if (cmd_i.rd_b) begin
      rd_addr = b_q[hlrc_pkg::NODE_W-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd_i.wr_a | cmd_i.wr_b;
    wr_addr = cmd_i.wr_a ? a_q[hlrc_pkg::NODE_W-1:0] : b_q[hlrc_pkg::NODE_W-1:0];
    wr_data = row_eff | (cmd_i.wr_a
                ? (hlrc_pkg::row_t'(1) << b_q[hlrc_pkg::NODE_W-1:0])
                : (hlrc_pkg::row_t'(1) << a_q[hlrc_pkg::NODE_W-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      present_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
      reached_q <= '0;
      frontier_q <= '0;
    end else begin
      rd_vld_q  <= row_vld_q[rd_addr];
      rd_pend_q <= cmd_i.scan_step && (pend_q != '0);
      if (cmd_i.clear) begin
        row_vld_q <= '0;
        present_q <= '0;
      end else if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.wr_b) begin
        present_q <= present_q
                   | (hlrc_pkg::row_t'(1) << a_q[hlrc_pkg::NODE_W-1:0])
                   | (hlrc_pkg::row_t'(1) << b_q[hlrc_pkg::NODE_W-1:0]);
      end
      if (cmd_i.q_init) begin
        reached_q  <= src_bit;
        frontier_q <= src_bit;
      end else if (cmd_i.hop_end) begin
        reached_q  <= reached_q | next_set;
        frontier_q <= next_set;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      a_q <= node_a_i;
      b_q <= node_b_i;
    end
    if (cmd_i.q_init) begin
      hop_q       <= hop_limit_i;
      hops_left_q <= hop_limit_i;
    end else if (cmd_i.hop_end) begin
      hops_left_q <= hops_left_q - 1'b1;
    end
    if (cmd_i.scan_start) begin
      pend_q <= frontier_q;
      acc_q  <= '0;
    end else if (cmd_i.scan_step) begin
      if (pend_q != '0) begin
        pend_q[ffs_idx] <= 1'b0;
      end
      if (rd_pend_q) begin
        acc_q <= acc_q | row_eff;
      end
    end
    if (cmd_i.cnt_start) begin
      sh_q   <= SH_W'(present_q & ~reached_q);
      cnt_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.cnt_step) begin
      sh_q   <= sh_q >> 8;
      cnt_q  <= cnt_q + hlrc_pkg::CNT_W'($countones(sh_q[7:0]));
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_cnt_q <= cnt_q;
      out_src_q <= a_q;
      out_hop_q <= hop_q;
    end
  end

  always_comb begin
    status_o.edge_ok   = ({1'b0, a_q} < hlrc_pkg::NODES_LIM)
                       && ({1'b0, b_q} < hlrc_pkg::NODES_LIM);
    status_o.walk_done = (hops_left_q == '0) || (frontier_q == '0);
    status_o.scan_done = (pend_q == '0) && !rd_pend_q;
    status_o.cnt_done  = step_q == hlrc_pkg::STEP_W'(hlrc_pkg::CNT_STEPS - 1);
    status_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o         = out_vld_q;
  assign unreachable_count_o = out_cnt_q;
  assign source_echo_o       = out_src_q;
  assign hop_echo_o          = out_hop_q;

endmodule

`default_nettype wire

/* rtl/hlrc_ctrl.sv */
`default_nettype none

module hlrc_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire [hlrc_pkg::MODE_W-1:0]   mode_i,
  output logic                         in_ready_o,
  input  wire hlrc_pkg::status_t       status_i,
  output hlrc_pkg::cmd_t               cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDA  = 4'd1;
  localparam logic [3:0] ST_WRA  = 4'd2;
  localparam logic [3:0] ST_RDB  = 4'd3;
  localparam logic [3:0] ST_WRB  = 4'd4;
  localparam logic [3:0] ST_TEST = 4'd5;
  localparam logic [3:0] ST_SCAN = 4'd6;
  localparam logic [3:0] ST_HOP  = 4'd7;
  localparam logic [3:0] ST_CNT  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            hlrc_pkg::MODE_ADD: begin
              cmd_o.cap = 1'b1;
              state_d   = ST_RDA;
            end
            hlrc_pkg::MODE_QUERY: begin
              cmd_o.cap    = 1'b1;
              cmd_o.q_init = 1'b1;
              state_d      = ST_TEST;
            end
            hlrc_pkg::MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = status_i.edge_ok ? ST_WRA : ST_IDLE;
      end
      ST_WRA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.wr_b = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_TEST: begin
        if (status_i.walk_done) begin
          cmd_o.cnt_start = 1'b1;
          state_d         = ST_CNT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_HOP;
        end
      end
      ST_HOP: begin
        cmd_o.hop_end = 1'b1;
        state_d       = ST_TEST;
      end
      ST_CNT: begin
        cmd_o.cnt_step = 1'b1;
        if (status_i.cnt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
